FILE: rtl/core/polygon_line_lateral_span_assert.svh
// Assertion macros for the lateral span block and its port checker.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef POLYGON_LINE_LATERAL_SPAN_ASSERT_SVH
`define POLYGON_LINE_LATERAL_SPAN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/plls_pkg.sv
// Shared types and constants of the polygon lateral span block.
// No dependencies; imported by the controller, datapath and top level.
package plls_pkg;

  typedef enum logic [1:0] {
    STAT_FOUND = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_FEW   = 2'd2
  } span_status_t;

  localparam int unsigned MIN_VERTICES = 3;
  localparam logic [1:0]  COUNT_SAT    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic test;
    logic absv;
    logic prep;
    logic iter;
    logic calc;
    logic upd;
    logic post;
    logic emit;
    logic sel_close;
  } plls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic last;
    logic in_range;
    logic equal_s;
    logic out_free;
  } plls_stat_t;

endpackage

FILE: rtl/core/plls_ctrl.sv
// Sequencer of the lateral span block: walks each edge through test,
// magnitude, divide iterations and min/max update. Uses plls_pkg.
module plls_ctrl
  import plls_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  plls_stat_t stat,
  output logic       in_stall,
  output plls_cmd_t  cmd
);

  localparam int CNT_W = $clog2(COORD_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEST,
    S_ABS,
    S_PREP,
    S_ITER,
    S_CALC,
    S_UPD,
    S_POST,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic               closing_r, closing_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    closing_nxt   = closing_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.sel_close = closing_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          closing_nxt = 1'b0;
          // first vertex has no incoming edge
          state_nxt   = stat.count_zero ? S_POST : S_TEST;
        end
      end
      S_TEST: begin
        cmd.test  = 1'b1;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        cmd.absv = 1'b1;
        if (!stat.in_range) begin
          state_nxt = closing_r ? S_EMIT : S_POST;
        end else if (stat.equal_s) begin
          state_nxt = S_CALC;
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = CNT_W'(COORD_WIDTH - 1);
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_CALC;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = closing_r ? S_EMIT : S_POST;
      end
      S_POST: begin
        cmd.post = 1'b1;
        if (stat.last) begin
          closing_nxt = 1'b1;
          state_nxt   = S_TEST;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      closing_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      closing_r <= closing_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: rtl/core/plls_dp.sv
// Datapath of the lateral span block: polygon state, edge operands,
// bit-serial scaled divider, min/max tracking and output register. Uses plls_pkg.
module plls_dp
  import plls_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  plls_cmd_t                     cmd,
  output plls_stat_t                    stat,
  input  logic signed [COORD_WIDTH-1:0] in_point_s,
  input  logic signed [COORD_WIDTH-1:0] in_point_l,
  input  logic signed [COORD_WIDTH-1:0] in_query_s,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic signed [COORD_WIDTH-1:0] out_l_min,
  output logic signed [COORD_WIDTH-1:0] out_l_max
);

  localparam int W = COORD_WIDTH;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  // polygon state
  logic signed [W-1:0] first_s_r, first_l_r, prev_s_r, prev_l_r, query_r;
  logic signed [W-1:0] cur_s_r, cur_l_r;
  logic                last_r;
  logic [1:0]          count_r;
  logic signed [W-1:0] min_r, max_r;
  logic                hit_r;

  // edge operands
  logic [W:0]          dq_r, ds_r, dl_r;
  logic signed [W-1:0] l0_r;
  logic                in_range_r, equal_r, dir_r;
  logic [W-1:0]        a_r, b_r, dsh_r, ba_r;
  logic [W-1:0]        rem_r, quo_r;
  logic signed [W-1:0] l_r;

  // output register
  logic                out_valid_r;
  span_status_t        out_status_r;
  logic signed [W-1:0] out_l_min_r, out_l_max_r;

  function automatic logic [W-1:0] mag(input logic [W:0] x);
    logic [W:0] n;
    n = x[W] ? (~x + 1'b1) : x;
    return n[W-1:0];
  endfunction

  // edge endpoint selection
  logic signed [W-1:0] s0, l0, s1, l1;
  logic                range_nxt;

  always_comb begin
    s0 = cmd.sel_close ? cur_s_r   : prev_s_r;
    l0 = cmd.sel_close ? cur_l_r   : prev_l_r;
    s1 = cmd.sel_close ? first_s_r : cur_s_r;
    l1 = cmd.sel_close ? first_l_r : cur_l_r;
    range_nxt = ((query_r >= s0) && (query_r <= s1)) ||
                ((query_r >= s1) && (query_r <= s0));
  end

  // one step of floor(a*d/b): double the remainder mod b, then add a mod b
  logic [W:0]   rem2;
  logic         c1, c2, dbit;
  logic [W-1:0] rm, rem_nxt, quo_nxt;

  always_comb begin
    rem2    = {rem_r, 1'b0};
    c1      = (rem2 >= {1'b0, b_r});
    rm      = c1 ? W'(rem2 - {1'b0, b_r}) : rem2[W-1:0];
    dbit    = dsh_r[W-1];
    c2      = (rm >= ba_r);
    if (dbit) begin
      rem_nxt = c2 ? (rm - ba_r) : (rm + a_r);
    end else begin
      rem_nxt = rm;
    end
    quo_nxt = {quo_r[W-2:0], 1'b0} + W'(c1) + W'(dbit & c2);
  end

  logic signed [W-1:0] l_nxt;
  assign l_nxt = dir_r ? (l0_r + quo_r) : (l0_r - quo_r);

  span_status_t status_nxt;
  always_comb begin
    if (count_r < 2'(MIN_VERTICES)) begin
      status_nxt = STAT_FEW;
    end else if (!hit_r) begin
      status_nxt = STAT_NONE;
    end else begin
      status_nxt = STAT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_s_r   <= '0;
      first_l_r   <= '0;
      prev_s_r    <= '0;
      prev_l_r    <= '0;
      query_r     <= '0;
      count_r     <= '0;
      min_r       <= MAX_POS;
      max_r       <= MIN_NEG;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture && (count_r == '0)) begin
        first_s_r <= in_point_s;
        first_l_r <= in_point_l;
        query_r   <= in_query_s;
      end
      if (cmd.post) begin
        prev_s_r <= cur_s_r;
        prev_l_r <= cur_l_r;
        count_r  <= (count_r == COUNT_SAT) ? COUNT_SAT : count_r + 1'b1;
      end
      if (cmd.upd) begin
        hit_r <= 1'b1;
        if (l_r < min_r) min_r <= l_r;
        if (l_r > max_r) max_r <= l_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        // back to the empty polygon
        first_s_r   <= '0;
        first_l_r   <= '0;
        prev_s_r    <= '0;
        prev_l_r    <= '0;
        query_r     <= '0;
        count_r     <= '0;
        min_r       <= MAX_POS;
        max_r       <= MIN_NEG;
        hit_r       <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_s_r <= in_point_s;
      cur_l_r <= in_point_l;
      last_r  <= in_last_vertex;
    end
    if (cmd.test) begin
      dq_r       <= {query_r[W-1], query_r} - {s0[W-1], s0};
      ds_r       <= {s1[W-1], s1} - {s0[W-1], s0};
      dl_r       <= {l1[W-1], l1} - {l0[W-1], l0};
      l0_r       <= l0;
      in_range_r <= range_nxt;
      equal_r    <= (s0 == s1);
      rem_r      <= '0;
      quo_r      <= '0;
    end
    if (cmd.absv) begin
      a_r   <= mag(dq_r);
      b_r   <= mag(ds_r);
      dsh_r <= mag(dl_r);
      dir_r <= !dl_r[W];
    end
    if (cmd.prep) begin
      ba_r <= b_r - a_r;
    end
    if (cmd.iter) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dsh_r <= {dsh_r[W-2:0], 1'b0};
    end
    if (cmd.calc) begin
      l_r <= l_nxt;
    end
    if (cmd.emit) begin
      out_status_r <= status_nxt;
      out_l_min_r  <= (status_nxt == STAT_FOUND) ? min_r : MAX_POS;
      out_l_max_r  <= (status_nxt == STAT_FOUND) ? max_r : MIN_NEG;
    end
  end

  always_comb begin
    stat.count_zero = (count_r == '0);
    stat.last       = last_r;
    stat.in_range   = in_range_r;
    stat.equal_s    = equal_r;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_l_min  = out_l_min_r;
  assign out_l_max  = out_l_max_r;

endmodule

FILE: rtl/core/polygon_line_lateral_span.sv
// Non-final vertex: after accept, test, magnitude, divider set-up, divide iterations,
// span calculation, min/max update and post; an edge that misses skips to post, an
// edge of zero s extent skips the divider, and the first vertex of a polygon goes
// straight to post. Last vertex: both edges; one quotient bit per cycle in the divider.
// The result follows the closing edge, later only while an earlier result still waits.
// Reset (synchronous, rst_n low) empties the polygon and drops any pending result.
module polygon_line_lateral_span
  import plls_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_s,
  input  logic signed [COORD_WIDTH-1:0] in_point_l,
  input  logic signed [COORD_WIDTH-1:0] in_query_s,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic signed [COORD_WIDTH-1:0] out_l_min,
  output logic signed [COORD_WIDTH-1:0] out_l_max
);

  plls_cmd_t  cmd;
  plls_stat_t stat;

  plls_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  plls_dp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_point_s     (in_point_s),
    .in_point_l     (in_point_l),
    .in_query_s     (in_query_s),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_l_min      (out_l_min),
    .out_l_max      (out_l_max)
  );

endmodule

FILE: rtl/core/plls_checker.sv
// Port-level checks of the lateral span block, bound to its top level.
// Uses plls_pkg and the macros of polygon_line_lateral_span_assert.svh.
`include "polygon_line_lateral_span_assert.svh"

module plls_checker
  import plls_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_status,
  input logic signed [COORD_WIDTH-1:0] out_l_min,
  input logic signed [COORD_WIDTH-1:0] out_l_max
);

  localparam logic [COORD_WIDTH-1:0] MAX_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // the block always stays busy after accepting a request
  `PLLS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "ready right after a request")

  `PLLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_l_min) && $stable(out_l_max), "stalled result changed")

  `PLLS_ASSERT_NOW(a_span_order, out_valid && (out_status == STAT_FOUND), out_l_min <= out_l_max, "span min above max")

  `PLLS_ASSERT_NOW(a_sentinels, out_valid && (out_status != STAT_FOUND), (out_l_min == MAX_POS) && (out_l_max == MIN_NEG), "missing sentinel extremes")

endmodule

bind polygon_line_lateral_span plls_checker #(.COORD_WIDTH(COORD_WIDTH)) u_plls_checker (.*);
